FILE: src/vsr_pkg.sv
`default_nettype none
package vsr_pkg;

   localparam int DEFAULT_STACK_DEPTH = 16;

   localparam int OP_W     = 3;
   localparam int VALUE_W  = 64;
   localparam int POS_W    = 4;
   localparam int STATUS_W = 2;
   localparam int ECOUNT_W = 5;

   localparam logic [VALUE_W-1:0] QNAN_BITS = 64'h7FF8_0000_0000_0000;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH  = 3'd0,
      OP_POP   = 3'd1,
      OP_ROLL  = 3'd2,
      OP_PEEK  = 3'd3,
      OP_CLEAR = 3'd4
   } vsr_op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 2'd0,
      ST_FULL    = 2'd1,
      ST_INVALID = 2'd2
   } vsr_status_type;

   typedef struct packed {
      logic [OP_W-1:0]    operation;
      logic [VALUE_W-1:0] value;
      logic [POS_W-1:0]   position;
   } vsr_req_type;

endpackage
`default_nettype wire

FILE: src/vsr_in_stage.sv
`default_nettype none
module vsr_in_stage
   import vsr_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [OP_W-1:0]    req_operation,
   input  wire logic [VALUE_W-1:0] req_value,
   input  wire logic [POS_W-1:0]   req_position,
   output logic                    held_valid,
   output vsr_req_type             held_req,
   input  wire logic               held_take
);

   logic        valid_ff;
   logic        valid_in;
   vsr_req_type req_ff;
   logic        accept;

   assign req_ready = !valid_ff || held_take;
   assign accept    = req_valid && req_ready;

   always_comb begin
      priority if (accept) begin
         valid_in = 1'b1;
      end else if (held_take) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff.operation <= req_operation;
         req_ff.value     <= req_value;
         req_ff.position  <= req_position;
      end
   end

   assign held_valid = valid_ff;
   assign held_req   = req_ff;

endmodule
`default_nettype wire

FILE: src/vsr_core.sv
`default_nettype none
module vsr_core
   import vsr_pkg::*;
#(
   parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 held_valid,
   input  wire vsr_req_type          held_req,
   output logic                      held_take,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [VALUE_W-1:0]        rsp_data,
   output logic [STATUS_W-1:0]       rsp_status,
   output logic [ECOUNT_W-1:0]       rsp_entry_count
);

   localparam int CNT_W = $clog2(STACK_DEPTH + 1);

   // entry 0 is the top of the stack
   logic [VALUE_W-1:0]  entries_ff [STACK_DEPTH];
   logic [VALUE_W-1:0]  entries_in [STACK_DEPTH];
   logic [CNT_W-1:0]    count_ff;
   logic [CNT_W-1:0]    count_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic [VALUE_W-1:0]  data_ff;
   logic [VALUE_W-1:0]  data_in;
   vsr_status_type      status_ff;
   vsr_status_type      status_in;
   logic [ECOUNT_W-1:0] ecount_ff;
   logic [31:0]         count_wide;

   logic               do_push;
   logic               do_pop;
   logic               do_roll;
   logic               not_full;
   logic               not_empty;
   logic               pos_ok;
   logic [VALUE_W-1:0] picked;

   assign held_take  = held_valid && (!rsp_valid_ff || rsp_ready);
   assign not_full   = count_ff < CNT_W'(STACK_DEPTH);
   assign not_empty  = count_ff != '0;
   assign pos_ok     = {28'd0, held_req.position} < 32'(count_ff);

   always_comb begin
      picked = '0;
      for (int i = 0; i < STACK_DEPTH; i++) begin
         if (i == int'(held_req.position)) begin
            picked = entries_ff[i];
         end
      end
   end

   always_comb begin
      do_push   = 1'b0;
      do_pop    = 1'b0;
      do_roll   = 1'b0;
      count_in  = count_ff;
      data_in   = '0;
      status_in = ST_OK;
      unique case (vsr_op_type'(held_req.operation))
         OP_PUSH: begin
            if (not_full) begin
               do_push  = 1'b1;
               count_in = count_ff + CNT_W'(1);
            end else begin
               status_in = ST_FULL;
            end
         end
         OP_POP: begin
            if (not_empty) begin
               do_pop   = 1'b1;
               count_in = count_ff - CNT_W'(1);
               data_in  = entries_ff[0];
            end else begin
               data_in   = QNAN_BITS;
               status_in = ST_INVALID;
            end
         end
         OP_ROLL: begin
            if (!pos_ok) begin
               status_in = ST_INVALID;
            end else begin
               do_roll = held_req.position != '0;
            end
         end
         OP_PEEK: begin
            if (pos_ok) begin
               data_in = picked;
            end else begin
               data_in   = QNAN_BITS;
               status_in = ST_INVALID;
            end
         end
         OP_CLEAR: begin
            count_in = '0;
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_entry
      logic [VALUE_W-1:0] below;
      logic [VALUE_W-1:0] above;
      logic               in_span;

      if (i == 0) begin : g_top
         assign above = held_req.value;
      end else begin : g_rest
         assign above = entries_ff[i-1];
      end

      if (i == STACK_DEPTH - 1) begin : g_bottom
         assign below = entries_ff[i];
      end else begin : g_upper
         assign below = entries_ff[i+1];
      end

      assign in_span = 32'(i) <= {28'd0, held_req.position};

      always_comb begin
         entries_in[i] = entries_ff[i];
         if (held_take) begin
            priority if (do_push) begin
               entries_in[i] = above;
            end else if (do_pop) begin
               entries_in[i] = below;
            end else if (do_roll && i == 0) begin
               entries_in[i] = picked;
            end else if (do_roll && in_span) begin
               entries_in[i] = above;
            end else begin
               entries_in[i] = entries_ff[i];
            end
         end
      end

      always_ff @(posedge clock) begin
         entries_ff[i] <= entries_in[i];
      end
   end

   always_comb begin
      priority if (held_take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign count_wide = 32'(count_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (held_take) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (held_take) begin
         data_ff   <= data_in;
         status_ff <= status_in;
         ecount_ff <= count_wide[ECOUNT_W-1:0];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data        = data_ff;
   assign rsp_status      = status_ff;
   assign rsp_entry_count = ecount_ff;

endmodule
`default_nettype wire

FILE: src/value_stack_with_roll.sv
// Bounded LIFO of 64-bit words with push, pop, roll, peek and clear. Each
// operation beat gives exactly one result beat carrying the data word, a status
// (ok, push dropped because full, empty or bad position) and the entry count
// after the operation. One operation is taken per clock when the result side
// keeps up; a beat passes through an input register and then a result
// register before its result is offered. The stack is a register file whose
// affected entries all shift in the same clock for push, pop and roll, and peek
// reads an entry directly. Stored words need no reset.
`default_nettype none
module value_stack_with_roll
   import vsr_pkg::*;
#(
   parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [OP_W-1:0]      req_operation,
   input  wire logic [VALUE_W-1:0]   req_value,
   input  wire logic [POS_W-1:0]     req_position,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [VALUE_W-1:0]        rsp_data,
   output logic [STATUS_W-1:0]       rsp_status,
   output logic [ECOUNT_W-1:0]       rsp_entry_count
);

   logic        held_valid;
   vsr_req_type held_req;
   logic        held_take;

   vsr_in_stage u_in (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operation (req_operation),
      .req_value     (req_value),
      .req_position  (req_position),
      .held_valid    (held_valid),
      .held_req      (held_req),
      .held_take     (held_take)
   );

   vsr_core #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_core (
      .clock           (clock),
      .reset           (reset),
      .held_valid      (held_valid),
      .held_req        (held_req),
      .held_take       (held_take),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_data        (rsp_data),
      .rsp_status      (rsp_status),
      .rsp_entry_count (rsp_entry_count)
   );

endmodule
`default_nettype wire

FILE: src/vsr_checker.sv
`default_nettype none
module vsr_checker
   import vsr_pkg::*;
#(
   parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH
) (
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                rsp_valid,
   input wire logic                rsp_ready,
   input wire logic [VALUE_W-1:0]  rsp_data,
   input wire logic [STATUS_W-1:0] rsp_status,
   input wire logic [ECOUNT_W-1:0] rsp_entry_count
);

   // stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data)
         && $stable(rsp_status) && $stable(rsp_entry_count))
      else $error("result beat changed while stalled");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (STACK_DEPTH > 31) || (32'(rsp_entry_count) <= STACK_DEPTH))
      else $error("entry count above depth");

   a_invalid_nan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_INVALID |-> rsp_data == QNAN_BITS
         || rsp_data == '0)
      else $error("invalid status with unexpected data");

   a_full_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_FULL |-> rsp_data == '0
         && (STACK_DEPTH > 31 || 32'(rsp_entry_count) == STACK_DEPTH))
      else $error("full status with bad data or count");

endmodule

bind value_stack_with_roll vsr_checker #(
   .STACK_DEPTH (STACK_DEPTH)
) u_vsr_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_data        (rsp_data),
   .rsp_status      (rsp_status),
   .rsp_entry_count (rsp_entry_count)
);
`default_nettype wire

FILE: dv/value_stack_with_roll_tb.sv
`timescale 1ns / 100ps

module value_stack_with_roll_tb;
   import vsr_pkg::*;

   localparam int DEPTH        = DEFAULT_STACK_DEPTH;
   localparam int RANDOM_ITEMS = 700;
   localparam int DRAIN_EVERY  = 200;
   localparam int IDLE_LIMIT   = 2000;
   localparam int TAIL_CYCLES  = 16;

   localparam logic [OP_W-1:0] OP_UNUSED_LOW = 3'd5;
   localparam logic [OP_W-1:0] OP_UNUSED_TOP = 3'd7;

   typedef struct packed {
      logic [VALUE_W-1:0]  data;
      logic [STATUS_W-1:0] status;
      logic [ECOUNT_W-1:0] entry_count;
   } stack_result_t;

   typedef struct {
      logic [OP_W-1:0]    op;
      logic [VALUE_W-1:0] value;
      logic [POS_W-1:0]   pos;
      bit                 typed;
      stack_result_t      want;
   } directed_row_t;

   logic                clock;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [OP_W-1:0]     req_operation = '0;
   logic [VALUE_W-1:0]  req_value = '0;
   logic [POS_W-1:0]    req_position = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [VALUE_W-1:0]  rsp_data;
   logic [STATUS_W-1:0] rsp_status;
   logic [ECOUNT_W-1:0] rsp_entry_count;

   logic [VALUE_W-1:0] stack_word [DEPTH];
   int                 stack_fill = 0;
   stack_result_t      results_due [$];
   stack_result_t      rsp_due;
   directed_row_t      directed_rows [$];

   int error_count = 0;
   int beats_sent = 0;
   int results_seen = 0;
   int op_seen [8];
   int full_hits = 0;
   int invalid_hits = 0;
   int burst_left = 0;
   int idle_cycles = 0;
   int stall_mode = 0;
   int stall_left = 0;

   value_stack_with_roll uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_operation   (req_operation),
      .req_value       (req_value),
      .req_position    (req_position),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_data        (rsp_data),
      .rsp_status      (rsp_status),
      .rsp_entry_count (rsp_entry_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic stack_result_t stack_predict(input logic [OP_W-1:0] op,
                                                   input logic [VALUE_W-1:0] value,
                                                   input logic [POS_W-1:0] pos);
      stack_result_t      r;
      int                 src;
      logic [VALUE_W-1:0] moved;
      r.data = '0;
      r.status = ST_OK;
      case (op)
         OP_PUSH: begin
            if (stack_fill < DEPTH) begin
               stack_word[stack_fill] = value;
               stack_fill++;
            end else begin
               r.status = ST_FULL;
            end
         end
         OP_POP: begin
            if (stack_fill == 0) begin
               r.data = QNAN_BITS;
               r.status = ST_INVALID;
            end else begin
               stack_fill--;
               r.data = stack_word[stack_fill];
            end
         end
         OP_ROLL: begin
            if (pos >= stack_fill) begin
               r.status = ST_INVALID;
            end else if (pos != 0) begin
               src = stack_fill - 1 - pos;
               moved = stack_word[src];
               for (int i = src; i < stack_fill - 1; i++)
                  stack_word[i] = stack_word[i + 1];
               stack_word[stack_fill - 1] = moved;
            end
         end
         OP_PEEK: begin
            if (pos >= stack_fill) begin
               r.data = QNAN_BITS;
               r.status = ST_INVALID;
            end else begin
               r.data = stack_word[stack_fill - 1 - pos];
            end
         end
         OP_CLEAR: begin
            stack_fill = 0;
         end
         default: begin
         end
      endcase
      r.entry_count = stack_fill[ECOUNT_W-1:0];
      return r;
   endfunction

   task automatic report_mismatch(input string field, input logic [VALUE_W-1:0] got,
                                  input logic [VALUE_W-1:0] want);
      $display("%0t: mismatch on %s: got %h, expected %h", $time, field, got, want);
      error_count++;
   endtask

   task automatic add_row(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] value,
                          input logic [POS_W-1:0] pos, input bit typed,
                          input logic [VALUE_W-1:0] data, input logic [STATUS_W-1:0] status,
                          input logic [ECOUNT_W-1:0] entry_count);
      directed_row_t row;
      row.op = op;
      row.value = value;
      row.pos = pos;
      row.typed = typed;
      row.want = {data, status, entry_count};
      directed_rows.push_back(row);
   endtask

   // one beat on the request side, paced in bursts with gaps between them
   task automatic send_beat(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] value,
                            input logic [POS_W-1:0] pos, input bit typed,
                            input stack_result_t want);
      stack_result_t got;
      int            gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_operation <= op;
      req_value <= value;
      req_position <= pos;
      do @(posedge clock); while (!req_ready);
      got = stack_predict(op, value, pos);
      results_due.push_back(typed ? want : got);
      beats_sent++;
      op_seen[op]++;
      if (got.status == ST_FULL)
         full_hits++;
      if (got.status == ST_INVALID)
         invalid_hits++;
   endtask

   task automatic wait_results_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (results_due.size() != 0);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (results_due.size() == 0) begin
            report_mismatch("result with nothing due", rsp_data, '0);
         end else begin
            rsp_due = results_due.pop_front();
            if (rsp_data !== rsp_due.data)
               report_mismatch("data", rsp_data, rsp_due.data);
            if (rsp_status !== rsp_due.status)
               report_mismatch("status", VALUE_W'(rsp_status), VALUE_W'(rsp_due.status));
            if (rsp_entry_count !== rsp_due.entry_count)
               report_mismatch("entry_count", VALUE_W'(rsp_entry_count),
                               VALUE_W'(rsp_due.entry_count));
         end
      end
   end

   // receiver back-pressure, changing character every so often
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= $urandom_range(0, 3);
         stall_left <= $urandom_range(20, 120);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= ($urandom_range(0, 3) != 0);
         2: rsp_ready <= ($urandom_range(0, 3) == 0);
         default: rsp_ready <= (stall_left % 7 == 0);
      endcase
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("value_stack_with_roll_tb: errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      logic [OP_W-1:0]    op;
      logic [VALUE_W-1:0] value;
      logic [POS_W-1:0]   pos;
      int                 useful;
      int                 since_drain;
      int                 push_weight;
      int                 pick;

      foreach (op_seen[i])
         op_seen[i] = 0;

      // empty store, unknown opcode, then fill to the brim and poke the edges
      add_row(OP_POP, '0, 4'd0, 1'b1, QNAN_BITS, ST_INVALID, 5'd0);
      add_row(OP_ROLL, '0, 4'd0, 1'b1, '0, ST_INVALID, 5'd0);
      add_row(OP_UNUSED_TOP, '1, 4'd15, 1'b1, '0, ST_OK, 5'd0);
      add_row(OP_PUSH, '1, 4'd0, 1'b1, '0, ST_OK, 5'd1);
      add_row(OP_PUSH, '0, 4'd15, 1'b1, '0, ST_OK, 5'd2);
      for (int i = 2; i < DEPTH; i++)
         add_row(OP_PUSH, {$urandom, $urandom}, 4'd0, 1'b0, '0, ST_OK, 5'd0);
      add_row(OP_PUSH, 64'h5555_5555_5555_5555, 4'd0, 1'b1, '0, ST_FULL, 5'd16);
      add_row(OP_PEEK, '0, 4'd15, 1'b0, '0, ST_OK, 5'd0);
      add_row(OP_ROLL, '0, 4'd15, 1'b0, '0, ST_OK, 5'd0);
      add_row(OP_ROLL, '0, 4'd0, 1'b1, '0, ST_OK, 5'd16);
      add_row(OP_POP, '0, 4'd0, 1'b0, '0, ST_OK, 5'd0);
      add_row(OP_ROLL, '0, 4'd15, 1'b1, '0, ST_INVALID, 5'd15);
      add_row(OP_PEEK, '0, 4'd15, 1'b1, QNAN_BITS, ST_INVALID, 5'd15);
      add_row(OP_CLEAR, '1, 4'd0, 1'b1, '0, ST_OK, 5'd0);

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_beat(directed_rows[i].op, directed_rows[i].value, directed_rows[i].pos,
                   directed_rows[i].typed, directed_rows[i].want);

      useful = 0;
      since_drain = 0;
      push_weight = 50;
      while (useful < RANDOM_ITEMS) begin
         if (useful % 50 == 0)
            push_weight = $urandom_range(15, 75);
         if (since_drain >= DRAIN_EVERY) begin
            wait_results_drained();
            since_drain = 0;
         end
         pick = $urandom_range(0, 99);
         if (pick < push_weight) begin
            op = OP_PUSH;
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 30)
               op = OP_POP;
            else if (pick < 58)
               op = OP_ROLL;
            else if (pick < 86)
               op = OP_PEEK;
            else if (pick < 92)
               op = OP_CLEAR;
            else
               op = OP_W'($urandom_range(OP_UNUSED_LOW, OP_UNUSED_TOP));
         end
         if (stack_fill > 0 && $urandom_range(0, 3) != 0)
            pos = POS_W'($urandom_range(0, stack_fill - 1));
         else
            pos = POS_W'($urandom_range(0, 15));
         case ($urandom_range(0, 9))
            0: value = '0;
            1: value = '1;
            2: value = QNAN_BITS;
            default: value = {$urandom, $urandom};
         endcase
         send_beat(op, value, pos, 1'b0, '0);
         if (op <= OP_CLEAR) begin
            useful++;
            since_drain++;
         end
      end

      wait_results_drained();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("run covered %0d beats, %0d results: push %0d pop %0d roll %0d peek %0d clear %0d",
               beats_sent, results_seen, op_seen[OP_PUSH], op_seen[OP_POP], op_seen[OP_ROLL],
               op_seen[OP_PEEK], op_seen[OP_CLEAR]);
      $display("unknown opcodes %0d, pushes onto a full store %0d, invalid pop/peek/roll %0d",
               op_seen[5] + op_seen[6] + op_seen[7], full_hits, invalid_hits);
      if (error_count == 0) begin
         $display("value_stack_with_roll_tb: clean");
      end else begin
         $display("value_stack_with_roll_tb: errors");
      end
      $finish;
   end

endmodule

FILE: sim.f
src/vsr_pkg.sv
src/vsr_in_stage.sv
src/vsr_core.sv
src/value_stack_with_roll.sv
src/vsr_checker.sv
dv/value_stack_with_roll_tb.sv
